// ===== rtl/mslcg_pkg.sv =====
package mslcg_pkg;

   // sizes
   localparam int STREAM_COUNT_DEF = 40;
   localparam int OP_W             = 3;
   localparam int INDEX_W          = 6;
   localparam int SEED_W           = 31;
   localparam int N_W              = 25;
   localparam int UNIF_W           = 25;
   localparam int DRAW_W           = 24;
   localparam int PROD_W           = SEED_W + 15;
   localparam int DPROD_W          = 49;

   // generator constants
   localparam logic [SEED_W:0]   PRIME_MOD  = 32'd2147483647;
   localparam logic [SEED_W-1:0] SEED_MAX   = 31'd2147483646;
   localparam logic [14:0]       FIRST_MUL  = 15'd24112;
   localparam logic [14:0]       SECOND_MUL = 15'd26143;
   localparam logic [N_W-1:0]    UNIT       = 25'd16777216;

   typedef enum logic [OP_W-1:0] {
      OP_ADVANCE = 3'd0,
      OP_SET     = 3'd1,
      OP_READ    = 3'd2,
      OP_DRAW    = 3'd3,
      OP_TRIAL   = 3'd4
   } opcode_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_MUL1,
      ST_FOLD1,
      ST_MUL2,
      ST_FOLD2,
      ST_DRAW,
      ST_EMIT
   } state_type;

   typedef struct packed {
      logic [OP_W-1:0]    opcode;
      logic [INDEX_W-1:0] stream_index;
      logic [SEED_W-1:0]  seed_value;
      logic [N_W-1:0]     range_size;
      logic [N_W-1:0]     probability;
   } req_type;

   typedef struct packed {
      logic [SEED_W-1:0] seed_out;
      logic [UNIF_W-1:0] uniform_numerator;
      logic [DRAW_W-1:0] integer_draw;
      logic              trial_result;
      logic              error_flag;
   } rsp_type;

   // controller to datapath
   typedef struct packed {
      logic load;
      logic mul_en;
      logic mul_first;
      logic fold_en;
      logic draw_en;
      logic emit;
   } cmd_type;

   // datapath to controller
   typedef struct packed {
      logic advance;
      logic out_busy;
   } sts_type;

   // power-on seed of each stream
   function automatic logic [SEED_W-1:0] init_seed(input logic [INDEX_W-1:0] idx);
      logic [SEED_W-1:0] s;
      case (idx)
         6'd0:  s = 31'd1973272912;
         6'd1:  s = 31'd281629770;
         6'd2:  s = 31'd20006270;
         6'd3:  s = 31'd1280689831;
         6'd4:  s = 31'd2096730329;
         6'd5:  s = 31'd1933576050;
         6'd6:  s = 31'd913566091;
         6'd7:  s = 31'd246780520;
         6'd8:  s = 31'd1363774876;
         6'd9:  s = 31'd604901985;
         6'd10: s = 31'd1511192140;
         6'd11: s = 31'd1259851944;
         6'd12: s = 31'd824064364;
         6'd13: s = 31'd150493284;
         6'd14: s = 31'd242708531;
         6'd15: s = 31'd75253171;
         6'd16: s = 31'd1964472944;
         6'd17: s = 31'd1202299975;
         6'd18: s = 31'd233217322;
         6'd19: s = 31'd1911216000;
         6'd20: s = 31'd726370533;
         6'd21: s = 31'd403498145;
         6'd22: s = 31'd993232223;
         6'd23: s = 31'd1103205531;
         6'd24: s = 31'd762430696;
         6'd25: s = 31'd1922803170;
         6'd26: s = 31'd1385516923;
         6'd27: s = 31'd76271663;
         6'd28: s = 31'd413682397;
         6'd29: s = 31'd726466604;
         6'd30: s = 31'd336157058;
         6'd31: s = 31'd1432650381;
         6'd32: s = 31'd1120463904;
         6'd33: s = 31'd595778810;
         6'd34: s = 31'd877722890;
         6'd35: s = 31'd1046574445;
         6'd36: s = 31'd68911991;
         6'd37: s = 31'd2088367019;
         6'd38: s = 31'd748545416;
         6'd39: s = 31'd622401386;
         default: s = '0;
      endcase
      return s;
   endfunction

endpackage

// ===== rtl/mslcg_ctrl.sv =====
module mslcg_ctrl (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_stall,
   input  mslcg_pkg::sts_type  sts,
   output mslcg_pkg::cmd_type  cmd
);

   mslcg_pkg::state_type state_ff, state_in;

   // state register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= mslcg_pkg::ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // next state and commands
   always_comb begin
      state_in  = state_ff;
      cmd       = '0;
      req_stall = 1'b1;
      case (state_ff)
         mslcg_pkg::ST_IDLE: begin
            req_stall = 1'b0;
            if (req_valid) begin
               cmd.load = 1'b1;
               state_in = mslcg_pkg::ST_MUL1;
            end
         end
         mslcg_pkg::ST_MUL1: begin
            cmd.mul_en    = 1'b1;
            cmd.mul_first = 1'b1;
            state_in = sts.advance ? mslcg_pkg::ST_FOLD1 : mslcg_pkg::ST_EMIT;
         end
         mslcg_pkg::ST_FOLD1: begin
            cmd.fold_en = 1'b1;
            state_in    = mslcg_pkg::ST_MUL2;
         end
         mslcg_pkg::ST_MUL2: begin
            cmd.mul_en = 1'b1;
            state_in   = mslcg_pkg::ST_FOLD2;
         end
         mslcg_pkg::ST_FOLD2: begin
            cmd.fold_en = 1'b1;
            state_in    = mslcg_pkg::ST_DRAW;
         end
         mslcg_pkg::ST_DRAW: begin
            cmd.draw_en = 1'b1;
            state_in    = mslcg_pkg::ST_EMIT;
         end
         mslcg_pkg::ST_EMIT: begin
            // wait for room in the output register
            if (!sts.out_busy) begin
               cmd.emit = 1'b1;
               state_in = mslcg_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = mslcg_pkg::ST_IDLE;
         end
      endcase
   end

endmodule

// ===== rtl/mslcg_datapath.sv =====
module mslcg_datapath #(
   parameter int STREAM_COUNT = mslcg_pkg::STREAM_COUNT_DEF
) (
   input  logic                clock,
   input  logic                reset,
   input  mslcg_pkg::req_type  req_payload,
   output logic                rsp_valid,
   input  logic                rsp_stall,
   output mslcg_pkg::rsp_type  rsp_payload,
   input  mslcg_pkg::cmd_type  cmd,
   output mslcg_pkg::sts_type  sts
);

   localparam int IDX_W   = (STREAM_COUNT > 1) ? $clog2(STREAM_COUNT) : 1;
   localparam int INDEX_W = mslcg_pkg::INDEX_W;
   localparam int SEED_W  = mslcg_pkg::SEED_W;
   localparam int PROD_W  = mslcg_pkg::PROD_W;
   localparam int DPROD_W = mslcg_pkg::DPROD_W;
   localparam int N_W     = mslcg_pkg::N_W;
   localparam int UNIF_W  = mslcg_pkg::UNIF_W;
   localparam int DRAW_W  = mslcg_pkg::DRAW_W;
   localparam logic [INDEX_W-1:0] LAST_IDX = INDEX_W'(STREAM_COUNT - 1);

   mslcg_pkg::req_type   req_ff;
   mslcg_pkg::rsp_type   rsp_ff, rsp_in;
   logic                 rsp_valid_ff;

   logic [SEED_W-1:0]    seed_mem [STREAM_COUNT];
   logic [STREAM_COUNT-1:0] valid_ff;
   logic [SEED_W-1:0]    seed_rd_ff;
   logic                 vld_rd_ff;
   logic [PROD_W-1:0]    prod_ff, prod_in;
   logic [SEED_W-1:0]    z_ff, z_in;
   logic [UNIF_W-1:0]    num_ff, num_in;
   logic [DPROD_W-1:0]   draw_ff, draw_in;

   logic [IDX_W-1:0]     rd_addr, wr_addr;
   logic                 in_range_req, in_range;
   logic                 adv_op, set_ok, mem_wr;
   logic [SEED_W-1:0]    seed_sel, mul_a, wr_data;
   logic [14:0]          mul_k;
   logic [SEED_W:0]      fold_sum;
   logic [N_W-1:0]       n_clamp, n_less;
   logic [N_W-1:0]       draw_q;
   logic [DRAW_W-1:0]    draw_res;

   // decode
   assign in_range_req = (req_payload.stream_index <= LAST_IDX);
   assign in_range     = (req_ff.stream_index <= LAST_IDX);
   assign adv_op       = (req_ff.opcode == mslcg_pkg::OP_ADVANCE) ||
                         (req_ff.opcode == mslcg_pkg::OP_DRAW) ||
                         (req_ff.opcode == mslcg_pkg::OP_TRIAL);
   assign set_ok       = (req_ff.opcode == mslcg_pkg::OP_SET) &&
                         (req_ff.seed_value >= 31'd1) &&
                         (req_ff.seed_value <= mslcg_pkg::SEED_MAX);
   assign rd_addr      = req_payload.stream_index[IDX_W-1:0];
   assign wr_addr      = req_ff.stream_index[IDX_W-1:0];
   assign mem_wr       = cmd.emit && in_range && (adv_op || set_ok);
   assign wr_data      = adv_op ? z_ff : req_ff.seed_value;

   assign sts.advance  = in_range && adv_op;
   assign sts.out_busy = rsp_valid_ff && rsp_stall;

   // request capture
   always_ff @(posedge clock) begin
      if (cmd.load) begin
         req_ff <= req_payload;
      end
   end

   // seed table, one write and one registered read
   always_ff @(posedge clock) begin
      if (mem_wr) begin
         seed_mem[wr_addr] <= wr_data;
      end
      if (cmd.load) begin
         seed_rd_ff <= seed_mem[rd_addr];
      end
   end

   // entries never written read as their power-on seed
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff  <= '0;
         vld_rd_ff <= 1'b0;
      end else begin
         if (mem_wr) begin
            valid_ff[wr_addr] <= 1'b1;
         end
         if (cmd.load) begin
            vld_rd_ff <= in_range_req && valid_ff[rd_addr];
         end
      end
   end

   assign seed_sel = vld_rd_ff ? seed_rd_ff : mslcg_pkg::init_seed(req_ff.stream_index);

   // shared constant multiplier
   assign mul_a   = cmd.mul_first ? seed_sel : z_ff;
   assign mul_k   = cmd.mul_first ? mslcg_pkg::FIRST_MUL : mslcg_pkg::SECOND_MUL;
   assign prod_in = PROD_W'(mul_a) * PROD_W'(mul_k);

   always_ff @(posedge clock) begin
      if (cmd.mul_en) begin
         prod_ff <= prod_in;
      end
   end

   // fold modulo 2^31-1: high part added to low part, one conditional subtract
   assign fold_sum = (SEED_W+1)'(prod_ff[SEED_W-1:0]) +
                     (SEED_W+1)'(prod_ff[PROD_W-1:SEED_W]);
   assign z_in     = (fold_sum >= mslcg_pkg::PRIME_MOD) ?
                     SEED_W'(fold_sum - mslcg_pkg::PRIME_MOD) : fold_sum[SEED_W-1:0];

   always_ff @(posedge clock) begin
      if (cmd.fold_en) begin
         z_ff <= z_in;
      end
   end

   // uniform numerator and scaled draw product
   assign num_in  = UNIF_W'(z_ff[SEED_W-1:7] | 24'd1) + 25'd1;
   assign n_clamp = (req_ff.range_size > mslcg_pkg::UNIT) ? mslcg_pkg::UNIT
                                                          : req_ff.range_size;
   assign draw_in = DPROD_W'(n_clamp) * DPROD_W'(num_in);

   always_ff @(posedge clock) begin
      if (cmd.draw_en) begin
         num_ff  <= num_in;
         draw_ff <= draw_in;
      end
   end

   // clamp the draw to n-1
   assign n_less = n_clamp - 25'd1;
   assign draw_q = draw_ff[DPROD_W-1:24];
   always_comb begin
      if (n_clamp == '0) begin
         draw_res = '0;
      end else if (draw_q > n_less) begin
         draw_res = n_less[DRAW_W-1:0];
      end else begin
         draw_res = draw_q[DRAW_W-1:0];
      end
   end

   // result assembly
   always_comb begin
      rsp_in = '0;
      if (in_range) begin
         case (req_ff.opcode)
            mslcg_pkg::OP_ADVANCE: begin
               rsp_in.seed_out          = z_ff;
               rsp_in.uniform_numerator = num_ff;
            end
            mslcg_pkg::OP_SET: begin
               rsp_in.error_flag = !set_ok;
            end
            mslcg_pkg::OP_READ: begin
               rsp_in.seed_out = seed_sel;
            end
            mslcg_pkg::OP_DRAW: begin
               rsp_in.seed_out          = z_ff;
               rsp_in.uniform_numerator = num_ff;
               rsp_in.integer_draw      = draw_res;
            end
            mslcg_pkg::OP_TRIAL: begin
               rsp_in.seed_out          = z_ff;
               rsp_in.uniform_numerator = num_ff;
               rsp_in.trial_result      = (num_ff < req_ff.probability);
            end
            default: begin
               rsp_in = '0;
            end
         endcase
      end
   end

   // output register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.emit) begin
         rsp_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.emit) begin
         rsp_ff <= rsp_in;
      end
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_ff;

endmodule

// ===== rtl/multi_stream_lcg_generator.sv =====
// advance, integer draw and trial step through MUL1, FOLD1, MUL2, FOLD2, DRAW and EMIT
// set and read seed go from MUL1 straight to EMIT; one item is taken at a time
// the advance uses one shared 31x15 constant multiplier twice, each use
// followed by a fold modulo 2^31-1, then the draw multiply
// reset (synchronous): clears valid bits so every stream reads its power-on seed
// again; no sweep over the seed table is needed
module multi_stream_lcg_generator #(
   parameter int STREAM_COUNT = mslcg_pkg::STREAM_COUNT_DEF
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_stall,
   input  mslcg_pkg::req_type  req_payload,
   output logic                rsp_valid,
   input  logic                rsp_stall,
   output mslcg_pkg::rsp_type  rsp_payload
);

   mslcg_pkg::cmd_type cmd;
   mslcg_pkg::sts_type sts;

   // sequencer
   mslcg_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .sts       (sts),
      .cmd       (cmd)
   );

   // seed table, modular multiplier and result register
   mslcg_datapath #(
      .STREAM_COUNT (STREAM_COUNT)
   ) u_datapath (
      .clock       (clock),
      .reset       (reset),
      .req_payload (req_payload),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_payload (rsp_payload),
      .cmd         (cmd),
      .sts         (sts)
   );

endmodule

// ===== rtl/mslcg_checker.sv =====
module mslcg_checker (
   input logic                clock,
   input logic                reset,
   input logic                req_valid,
   input logic                req_stall,
   input logic                rsp_valid,
   input logic                rsp_stall,
   input mslcg_pkg::rsp_type  rsp_payload
);

   // a held result stays put
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_payload))
      else $error("stalled result changed");

   // one item in flight: a transfer closes the input
   assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall |=> req_stall)
      else $error("input taken while busy");

   // a refused seed carries nothing else
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_payload.error_flag |->
         rsp_payload.seed_out == '0 && rsp_payload.uniform_numerator == '0 &&
         rsp_payload.integer_draw == '0 && !rsp_payload.trial_result)
      else $error("error result with payload");

   // the numerator matches the returned seed
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_payload.uniform_numerator != '0 |->
         rsp_payload.uniform_numerator ==
            25'(rsp_payload.seed_out[30:7] | 24'd1) + 25'd1)
      else $error("numerator does not match seed");

   // draw or trial results only come with an advance
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_payload.trial_result || rsp_payload.integer_draw != '0) |->
         rsp_payload.uniform_numerator != '0)
      else $error("variate without advance");

endmodule

bind multi_stream_lcg_generator mslcg_checker u_checker (
   .clock       (clock),
   .reset       (reset),
   .req_valid   (req_valid),
   .req_stall   (req_stall),
   .rsp_valid   (rsp_valid),
   .rsp_stall   (rsp_stall),
   .rsp_payload (rsp_payload)
);

// ===== tb/multi_stream_lcg_generator_tb.sv =====
`timescale 1ns / 100ps

module multi_stream_lcg_generator_tb;

   localparam int STREAMS = mslcg_pkg::STREAM_COUNT_DEF;
   localparam longint unsigned MODULUS = 64'd2147483647;
   localparam longint unsigned MUL_A = 64'd24112;
   localparam longint unsigned MUL_B = 64'd26143;
   localparam longint unsigned UNIT_NUM = 64'd16777216;
   localparam logic [30:0] SEED_TOP = 31'd2147483646;
   localparam logic [2:0] FIRST_UNUSED_OP = 3'd5;
   localparam logic [2:0] MID_UNUSED_OP = 3'd6;
   localparam logic [2:0] LAST_UNUSED_OP = 3'd7;
   localparam int ITEM_COUNT = 1150;
   localparam int HOLD_CYCLES = 60;
   localparam int WATCHDOG_LIMIT = 2000;
   localparam int DRAIN_CYCLES = 20;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_stall;
   mslcg_pkg::req_type req_payload = '0;
   logic rsp_valid;
   logic rsp_stall = 1'b0;
   mslcg_pkg::rsp_type rsp_payload;

   // power-on seeds of the forty streams
   logic [30:0] power_on_seed [40] = '{
      31'd1973272912, 31'd281629770, 31'd20006270, 31'd1280689831, 31'd2096730329,
      31'd1933576050, 31'd913566091, 31'd246780520, 31'd1363774876, 31'd604901985,
      31'd1511192140, 31'd1259851944, 31'd824064364, 31'd150493284, 31'd242708531,
      31'd75253171, 31'd1964472944, 31'd1202299975, 31'd233217322, 31'd1911216000,
      31'd726370533, 31'd403498145, 31'd993232223, 31'd1103205531, 31'd762430696,
      31'd1922803170, 31'd1385516923, 31'd76271663, 31'd413682397, 31'd726466604,
      31'd336157058, 31'd1432650381, 31'd1120463904, 31'd595778810, 31'd877722890,
      31'd1046574445, 31'd68911991, 31'd2088367019, 31'd748545416, 31'd622401386
   };

   logic [30:0] stream_seed [STREAMS];
   mslcg_pkg::req_type request_q[$];
   mslcg_pkg::rsp_type variate_q[$];
   int accepted_count = 0;
   int total_items = 0;
   int phase_len;
   int send_idle_pct;
   int recv_stall_pct;
   int error_count = 0;
   int hold_left = 0;
   logic hold_done = 1'b0;
   int idle_cycles = 0;

   multi_stream_lcg_generator u_dut (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_payload (req_payload),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_payload (rsp_payload)
   );

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   // idling pattern: receiver-heavy third, sender-heavy third, then none
   assign phase_len = total_items / 3;
   assign send_idle_pct = (accepted_count < phase_len) ? 31 :
                          (accepted_count < 2 * phase_len) ? 48 : 0;
   assign recv_stall_pct = (accepted_count < phase_len) ? 48 :
                           (accepted_count < 2 * phase_len) ? 31 : 0;

   // form the expected result; advance, draw and trial also advance the predicted stream state
   function automatic mslcg_pkg::rsp_type predict_variate(mslcg_pkg::req_type item);
      mslcg_pkg::rsp_type res;
      longint unsigned z;
      longint unsigned num;
      longint unsigned n;
      longint unsigned d;
      res = '0;
      if (item.stream_index >= STREAMS || item.opcode > mslcg_pkg::OP_TRIAL)
         return res;
      case (item.opcode)
         mslcg_pkg::OP_SET: begin
            if (item.seed_value >= 31'd1 && item.seed_value <= SEED_TOP)
               stream_seed[item.stream_index] = item.seed_value;
            else
               res.error_flag = 1'b1;
         end
         mslcg_pkg::OP_READ: begin
            res.seed_out = stream_seed[item.stream_index];
         end
         default: begin
            z = (longint'(stream_seed[item.stream_index]) * MUL_A) % MODULUS;
            z = (z * MUL_B) % MODULUS;
            stream_seed[item.stream_index] = z[30:0];
            num = ((z >> 7) | 64'd1) + 64'd1;
            res.seed_out = z[30:0];
            res.uniform_numerator = num[24:0];
            if (item.opcode == mslcg_pkg::OP_DRAW) begin
               n = longint'(item.range_size);
               if (n > UNIT_NUM)
                  n = UNIT_NUM;
               if (n == 0) begin
                  d = 0;
               end else begin
                  d = (n * num) >> 24;
                  if (d > n - 1)
                     d = n - 1;
               end
               res.integer_draw = d[23:0];
            end else if (item.opcode == mslcg_pkg::OP_TRIAL) begin
               res.trial_result = (num < longint'(item.probability));
            end
         end
      endcase
      return res;
   endfunction

   function automatic mslcg_pkg::req_type build_request(logic [2:0] op, logic [5:0] idx,
                                                        logic [30:0] seed, logic [24:0] n,
                                                        logic [24:0] p);
      mslcg_pkg::req_type r;
      r.opcode = op;
      r.stream_index = idx;
      r.seed_value = seed;
      r.range_size = n;
      r.probability = p;
      return r;
   endfunction

   // request driver with prediction at each accepted transfer
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
         for (int i = 0; i < STREAMS; i++)
            stream_seed[i] = power_on_seed[i];
      end else begin
         if (req_valid && !req_stall) begin
            variate_q.push_back(predict_variate(req_payload));
            accepted_count <= accepted_count + 1;
         end
         if (!req_valid || !req_stall) begin
            if (request_q.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
               req_payload <= request_q.pop_front();
               req_valid <= 1'b1;
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // result monitor and receiver stall
   always @(posedge clock) begin
      mslcg_pkg::rsp_type want;
      if (reset) begin
         rsp_stall <= 1'b0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            if (variate_q.size() == 0) begin
               $display("%0t unexpected result transfer: %p", $time, rsp_payload);
               error_count++;
            end else begin
               want = variate_q.pop_front();
               if (rsp_payload.seed_out !== want.seed_out) begin
                  $display("%0t seed_out: expected %0d, actual %0d",
                           $time, want.seed_out, rsp_payload.seed_out);
                  error_count++;
               end
               if (rsp_payload.uniform_numerator !== want.uniform_numerator) begin
                  $display("%0t uniform_numerator: expected %0d, actual %0d",
                           $time, want.uniform_numerator, rsp_payload.uniform_numerator);
                  error_count++;
               end
               if (rsp_payload.integer_draw !== want.integer_draw) begin
                  $display("%0t integer_draw: expected %0d, actual %0d",
                           $time, want.integer_draw, rsp_payload.integer_draw);
                  error_count++;
               end
               if (rsp_payload.trial_result !== want.trial_result) begin
                  $display("%0t trial_result: expected %0b, actual %0b",
                           $time, want.trial_result, rsp_payload.trial_result);
                  error_count++;
               end
               if (rsp_payload.error_flag !== want.error_flag) begin
                  $display("%0t error_flag: expected %0b, actual %0b",
                           $time, want.error_flag, rsp_payload.error_flag);
                  error_count++;
               end
            end
         end
         // one long hold-off once the no-idle stretch begins, so the block backs up
         if (hold_left != 0) begin
            hold_left <= hold_left - 1;
            rsp_stall <= 1'b1;
         end else if (!hold_done && phase_len != 0 && accepted_count >= 2 * phase_len) begin
            hold_left <= HOLD_CYCLES;
            hold_done <= 1'b1;
            rsp_stall <= 1'b1;
         end else begin
            rsp_stall <= ($urandom_range(99) < recv_stall_pct);
         end
      end
   end

   // watchdog on cycles without any transfer
   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= WATCHDOG_LIMIT) begin
         $display("FAIL");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   // stimulus, reset and end of run
   initial begin
      int pick;
      logic [2:0] op;
      logic [5:0] idx;
      logic [30:0] seed;
      logic [24:0] n;
      logic [24:0] p;

      // directed: power-on seeds, seed bounds, draw and trial extremes, out-of-range streams, unused opcodes
      request_q.push_back(build_request(mslcg_pkg::OP_READ, 6'd0, '0, '0, '0));
      request_q.push_back(build_request(mslcg_pkg::OP_READ, 6'd39, '1, '1, '1));
      request_q.push_back(build_request(mslcg_pkg::OP_ADVANCE, 6'd0, '0, '0, '0));
      request_q.push_back(build_request(mslcg_pkg::OP_SET, 6'd1, 31'd0, '0, '0));
      request_q.push_back(build_request(mslcg_pkg::OP_SET, 6'd1, 31'h7FFFFFFF, '0, '0));
      request_q.push_back(build_request(mslcg_pkg::OP_SET, 6'd1, 31'd1, '0, '0));
      request_q.push_back(build_request(mslcg_pkg::OP_ADVANCE, 6'd1, '0, '0, '0));
      request_q.push_back(build_request(mslcg_pkg::OP_READ, 6'd1, '0, '0, '0));
      request_q.push_back(build_request(mslcg_pkg::OP_SET, 6'd2, SEED_TOP, '0, '0));
      request_q.push_back(build_request(mslcg_pkg::OP_DRAW, 6'd2, '0, 25'd0, '0));
      request_q.push_back(build_request(mslcg_pkg::OP_DRAW, 6'd3, '0, 25'd1, '0));
      request_q.push_back(build_request(mslcg_pkg::OP_DRAW, 6'd4, '0, 25'd16777216, '0));
      request_q.push_back(build_request(mslcg_pkg::OP_DRAW, 6'd5, '0, 25'h1FFFFFF, '0));
      request_q.push_back(build_request(mslcg_pkg::OP_TRIAL, 6'd6, '0, '0, 25'd0));
      request_q.push_back(build_request(mslcg_pkg::OP_TRIAL, 6'd7, '0, '0, 25'd16777216));
      request_q.push_back(build_request(mslcg_pkg::OP_TRIAL, 6'd8, '0, '0, 25'h1FFFFFF));
      request_q.push_back(build_request(mslcg_pkg::OP_ADVANCE, 6'd40, '0, '0, '0));
      request_q.push_back(build_request(mslcg_pkg::OP_READ, 6'd63, '0, '0, '0));
      request_q.push_back(build_request(mslcg_pkg::OP_SET, 6'd63, 31'd5, '0, '0));
      request_q.push_back(build_request(FIRST_UNUSED_OP, 6'd0, '1, '1, '1));
      request_q.push_back(build_request(MID_UNUSED_OP, 6'd9, '1, '1, '1));
      request_q.push_back(build_request(LAST_UNUSED_OP, 6'd10, '1, '1, '1));
      request_q.push_back(build_request(mslcg_pkg::OP_TRIAL, 6'd39, '1, '1, 25'd8388608));
      request_q.push_back(build_request(mslcg_pkg::OP_DRAW, 6'd20, '1, 25'd1000, '1));
      request_q.push_back(build_request(mslcg_pkg::OP_READ, 6'd2, '0, '0, '0));

      // random: mostly valid operations on live streams, some noise
      while (request_q.size() < ITEM_COUNT) begin
         pick = int'($urandom_range(99));
         if (pick < 20)
            op = mslcg_pkg::OP_ADVANCE;
         else if (pick < 35)
            op = mslcg_pkg::OP_SET;
         else if (pick < 50)
            op = mslcg_pkg::OP_READ;
         else if (pick < 72)
            op = mslcg_pkg::OP_DRAW;
         else if (pick < 95)
            op = mslcg_pkg::OP_TRIAL;
         else
            op = 3'($urandom_range(LAST_UNUSED_OP, FIRST_UNUSED_OP));
         if ($urandom_range(99) < 94)
            idx = 6'($urandom_range(STREAMS - 1));
         else
            idx = 6'($urandom_range(63, STREAMS));
         case ($urandom_range(9))
            0: seed = 31'd0;
            1: seed = 31'h7FFFFFFF;
            default: seed = 31'($urandom_range(SEED_TOP, 1));
         endcase
         case ($urandom_range(3))
            0: n = 25'($urandom_range(16, 1));
            1: n = 25'($urandom_range(32'd16777216, 0));
            2: n = 25'($urandom());
            default: n = 25'($urandom_range(2000, 0));
         endcase
         case ($urandom_range(2))
            0: p = 25'($urandom_range(32'd16777216, 0));
            1: p = 25'($urandom());
            default: p = 25'($urandom_range(32'd16777216, 32'd16000000));
         endcase
         request_q.push_back(build_request(op, idx, seed, n, p));
      end
      total_items = request_q.size();

      repeat (5) @(posedge clock);
      reset <= 1'b0;

      while (request_q.size() != 0 || req_valid || variate_q.size() != 0)
         @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      if (error_count == 0 && variate_q.size() == 0)
         $display("PASS");
      else
         $display("FAIL");
      $finish;
   end

endmodule
